// ===== hw/rtl/h264rd_pkg.sv =====
// Shared types and constants of the H.264 RTP depacketizer.
`timescale 1ns / 1ps
`default_nettype none

package h264rd_pkg;

  // NAL unit type fields.
  localparam logic [4:0] FuAType     = 5'd28;
  localparam logic [4:0] SingleLimit = 5'd24;
  localparam int unsigned FuStartBit = 7;

  // Annex B start code, index 0 goes out first.
  localparam logic [3:0][7:0] StartCode = {8'h01, 8'h00, 8'h00, 8'h00};

  // Step of the last result of a start-code burst (four code bytes, then the header).
  localparam logic [2:0] LastStep = 3'd4;

  // Default depth of the command queue between front and back.
  localparam int unsigned DefaultFifoDepth = 4;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_FUA    = 2'd1,
    MODE_DROP   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_LATER  = 2'd2
  } pos_e;

  typedef enum logic [1:0] {
    CMD_ERR    = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_PREFIX = 2'd2
  } cmd_kind_e;

  // One classified command; a prefix command carries the NAL header byte.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        pdone;
    logic        nstart;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/h264rd_front.sv =====
// Front end: parses payload bytes and turns them into output commands.
`timescale 1ns / 1ps
`default_nettype none

module h264rd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        payload_byte_i,
  input  wire logic              payload_end_i,
  input  wire logic              accept_i,
  output logic                   cmd_valid_o,
  output h264rd_pkg::cmd_t       cmd_o
);
  import h264rd_pkg::*;

  pos_e       pos_q, pos_d;
  mode_e      mode_q, mode_d;
  logic [1:0] nri_q, nri_d;
  logic       start_q, start_d;

  logic [4:0] nal_type;
  logic       is_drop;

  assign nal_type = payload_byte_i[4:0];
  // Mode code 3 never occurs but behaves as dropping.
  assign is_drop  = (mode_q != MODE_SINGLE) && (mode_q != MODE_FUA);

  always_comb begin
    pos_d       = pos_q;
    mode_d      = mode_q;
    nri_d       = nri_q;
    start_d     = start_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind   = CMD_ERR;
    cmd_o.data   = 8'h00;
    cmd_o.pdone  = 1'b1;
    cmd_o.nstart = 1'b0;

    if (is_drop) begin
      if (payload_end_i) begin
        pos_d  = POS_FIRST;
        mode_d = MODE_SINGLE;
      end
    end else if (pos_q == POS_FIRST) begin
      if (nal_type == FuAType) begin
        if (payload_end_i) begin
          cmd_valid_o = 1'b1;
          pos_d       = POS_FIRST;
          mode_d      = MODE_SINGLE;
        end else begin
          nri_d   = payload_byte_i[6:5];
          start_d = 1'b0;
          mode_d  = MODE_FUA;
          pos_d   = POS_SECOND;
        end
      end else if ((nal_type != 5'd0) && (nal_type < SingleLimit)) begin
        start_d      = 1'b1;
        cmd_valid_o  = 1'b1;
        cmd_o.kind   = CMD_PREFIX;
        cmd_o.data   = payload_byte_i;
        cmd_o.pdone  = payload_end_i;
        cmd_o.nstart = 1'b1;
        mode_d       = MODE_SINGLE;
        pos_d        = payload_end_i ? POS_FIRST : POS_SECOND;
      end else begin
        cmd_valid_o = 1'b1;
        pos_d       = POS_FIRST;
        mode_d      = payload_end_i ? MODE_SINGLE : MODE_DROP;
      end
    end else if ((mode_q == MODE_FUA) && (pos_q == POS_SECOND)) begin
      if (payload_end_i) begin
        cmd_valid_o = 1'b1;
        pos_d       = POS_FIRST;
        mode_d      = MODE_SINGLE;
      end else begin
        start_d = payload_byte_i[FuStartBit];
        pos_d   = POS_LATER;
        if (payload_byte_i[FuStartBit]) begin
          cmd_valid_o  = 1'b1;
          cmd_o.kind   = CMD_PREFIX;
          cmd_o.data   = {1'b0, nri_q, nal_type};
          cmd_o.pdone  = 1'b0;
          cmd_o.nstart = 1'b1;
        end
      end
    end else begin
      cmd_valid_o  = 1'b1;
      cmd_o.kind   = CMD_BYTE;
      cmd_o.data   = payload_byte_i;
      cmd_o.pdone  = payload_end_i;
      cmd_o.nstart = start_q;
      if (payload_end_i) begin
        pos_d  = POS_FIRST;
        mode_d = MODE_SINGLE;
      end else begin
        pos_d  = POS_LATER;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_FIRST;
      mode_q  <= MODE_SINGLE;
      nri_q   <= 2'd0;
      start_q <= 1'b0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      mode_q  <= mode_d;
      nri_q   <= nri_d;
      start_q <= start_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/h264rd_cmd_fifo.sv =====
// Command queue between the parsing front end and the output back end.
`timescale 1ns / 1ps
`default_nettype none

module h264rd_cmd_fifo #(
  parameter int unsigned Depth = h264rd_pkg::DefaultFifoDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  h264rd_pkg::cmd_t       push_cmd_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output h264rd_pkg::cmd_t       head_cmd_o,
  output logic                   empty_o
);
  import h264rd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign head_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("command queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("push into full command queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("pop from empty command queue");

endmodule

`default_nettype wire

// ===== hw/rtl/h264rd_back.sv =====
// Back end: expands queued commands into result bytes in an output register.
`timescale 1ns / 1ps
`default_nettype none

module h264rd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  h264rd_pkg::cmd_t       cmd_i,
  input  wire logic              cmd_empty_i,
  output logic                   cmd_pop_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output logic [7:0]             out_byte_o,
  output logic                   item_done_o,
  output logic                   payload_done_o,
  output logic                   nal_start_o,
  output logic                   status_o
);
  import h264rd_pkg::*;

  logic [2:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       idone_q, idone_d;
  logic       pdone_q, pdone_d;
  logic       nstart_q, nstart_d;
  logic       status_q, status_d;

  logic load;
  logic last_step;

  // The output register takes a new result when it is free or being drained.
  assign load      = !cmd_empty_i && (!out_valid_q || pop_i);
  assign last_step = (cmd_i.kind != CMD_PREFIX) || (step_q == LastStep);
  assign cmd_pop_o = load && last_step;

  always_comb begin
    byte_d   = byte_q;
    idone_d  = idone_q;
    pdone_d  = pdone_q;
    nstart_d = nstart_q;
    status_d = status_q;
    unique case (cmd_i.kind)
      CMD_PREFIX: begin
        byte_d   = (step_q == LastStep) ? cmd_i.data : StartCode[step_q[1:0]];
        idone_d  = (step_q == LastStep);
        pdone_d  = (step_q == LastStep) && cmd_i.pdone;
        nstart_d = 1'b1;
        status_d = 1'b0;
      end
      CMD_BYTE: begin
        byte_d   = cmd_i.data;
        idone_d  = 1'b1;
        pdone_d  = cmd_i.pdone;
        nstart_d = cmd_i.nstart;
        status_d = 1'b0;
      end
      default: begin
        byte_d   = 8'h00;
        idone_d  = 1'b1;
        pdone_d  = 1'b1;
        nstart_d = 1'b0;
        status_d = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      step_d      = last_step ? 3'd0 : step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      idone_q  <= idone_d;
      pdone_q  <= pdone_d;
      nstart_q <= nstart_d;
      status_q <= status_d;
    end
  end

  assign empty_o        = !out_valid_q;
  assign out_byte_o     = byte_q;
  assign item_done_o    = idone_q;
  assign payload_done_o = pdone_q;
  assign nal_start_o    = nstart_q;
  assign status_o       = status_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LastStep) else $error("burst step out of range");

  a_error_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q) |-> (idone_q && pdone_q && !nstart_q && byte_q == 8'h00))
    else $error("error result with wrong marks");

  a_burst_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cmd_i.kind == CMD_PREFIX && step_q != LastStep) |=> (step_q != 3'd0))
    else $error("start-code burst ended early");

endmodule

`default_nettype wire

// ===== hw/rtl/h264_rtp_depacketizer.sv =====
// Top level of the streaming H.264 RTP depacketizer (single NAL and FU-A).
`timescale 1ns / 1ps
`default_nettype none

// Streaming H.264 RTP depacketizer. Payload bytes enter one per transfer on the
// push/full side, with payload_end_i high on the last byte of each RTP payload,
// and the Annex B byte stream leaves on the empty/pop side, one byte per
// transfer. A single NAL unit payload is passed through behind a 00 00 00 01
// start code; an FU-A payload loses its indicator and header bytes, and its
// start fragment is preceded by the start code and a rebuilt NAL header. A bad
// NAL type, or an FU-A payload that ends on its first or second byte, gives
// one result with status_o set and out_byte_o zero, and the rest of that
// payload is dropped silently. The front end classifies one input byte per
// clock while the queue is not full and writes at most one command into a
// queue of FifoDepth entries; the back end turns each command into one
// result, or into five results for a start-code burst, and delivers one
// result per clock through its output register while pop is high. So input
// runs at one byte and the output at one result per cycle when unstalled;
// each NAL start adds four extra results, which the queue absorbs; full
// rises only when the queue is full because the output side is slower or
// stalled. An accepted byte's results pass through the command queue and the
// output register; bytes that give no result never enter the queue.
module h264_rtp_depacketizer #(
  parameter int unsigned FifoDepth = h264rd_pkg::DefaultFifoDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] payload_byte_i,
  input  wire logic       payload_end_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            item_done_o,
  output logic            payload_done_o,
  output logic            nal_start_o,
  output logic            status_o
);
  import h264rd_pkg::*;

  logic in_xfer;
  logic cmd_valid;
  cmd_t cmd_new;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;

  // An input transfer always advances the parser; only bytes that produce
  // output are queued.
  assign in_xfer = push && !full;

  h264rd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .payload_byte_i (payload_byte_i),
    .payload_end_i  (payload_end_i),
    .accept_i       (in_xfer),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd_new)
  );

  h264rd_cmd_fifo #(
    .Depth (FifoDepth)
  ) u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_xfer && cmd_valid),
    .push_cmd_i (cmd_new),
    .full_o     (full),
    .pop_i      (cmd_pop),
    .head_cmd_o (cmd_head),
    .empty_o    (cmd_empty)
  );

  h264rd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_head),
    .cmd_empty_i    (cmd_empty),
    .cmd_pop_o      (cmd_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_byte_o     (out_byte_o),
    .item_done_o    (item_done_o),
    .payload_done_o (payload_done_o),
    .nal_start_o    (nal_start_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb_h264_rtp_depacketizer.sv =====
// Self-checking testbench for the streaming H.264 RTP depacketizer.
`timescale 1ns / 1ps

// Payload bytes are pushed one transfer at a time into the depacketizer. Each
// accepted byte runs through a local model of the RFC 6184 unpacking rules:
// - single NAL unit pass-through behind a start code
// - FU-A reassembly with a rebuilt NAL header
// - parse errors followed by silent dropping
// The model appends the Annex B bytes that the byte must produce to a queue.
// One process pops the block's output at random and compares every field of
// each popped byte with the oldest queued expectation. The same process runs a
// watchdog that ends the run when no transfer happens on either side for too
// long. Directed payloads come first, then random payloads under three idling
// profiles.
module tb_h264_rtp_depacketizer;
  import h264rd_pkg::*;

  // This limit only catches a hang, not the stalls that heavy idling gives.
  localparam int unsigned WatchdogLimit = 4000;
  // Cycles waited after the last expected byte is popped, before the verdict.
  localparam int unsigned DrainCycles   = 10;

  // One Annex B output byte together with its side flags.
  typedef struct packed {
    logic [7:0] data;
    logic       item_done;
    logic       payload_done;
    logic       nal_start;
    logic       status;
  } annexb_byte_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       push           = 1'b0;
  logic [7:0] payload_byte_i = 8'h00;
  logic       payload_end_i  = 1'b0;
  logic       pop            = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte_o;
  logic       item_done_o;
  logic       payload_done_o;
  logic       nal_start_o;
  logic       status_o;

  // Depacketizer state as the model sees it.
  mode_e      unpack_mode;
  pos_e       unpack_pos;
  logic [1:0] fu_nri;
  logic       nal_begins;

  annexb_byte_t expected_annexb[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  int unsigned stall_cycles  = 0;
  // Bytes accepted that were not simply swallowed by drop mode.
  int unsigned live_bytes    = 0;

  h264_rtp_depacketizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .payload_byte_i(payload_byte_i),
    .payload_end_i (payload_end_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .item_done_o   (item_done_o),
    .payload_done_o(payload_done_o),
    .nal_start_o   (nal_start_o),
    .status_o      (status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Model of the unpacking rules.
  // ---------------------------------------------------------------------------

  task automatic add_annexb(input logic [7:0] data, input logic pdone,
                            input logic nstart, input logic status);
    expected_annexb.push_back('{data: data, item_done: 1'b0, payload_done: pdone,
                                nal_start: nstart, status: status});
  endtask

  // Start code burst: four code bytes, then the NAL header byte.
  task automatic add_start_code(input logic [7:0] header, input logic pdone);
    for (int k = 0; k < 4; k++) begin
      add_annexb(StartCode[k], 1'b0, 1'b1, 1'b0);
    end
    add_annexb(header, pdone, 1'b1, 1'b0);
  endtask

  task automatic finish_payload();
    unpack_pos  = POS_FIRST;
    unpack_mode = MODE_SINGLE;
  endtask

  // Works out the output bytes caused by one accepted payload byte.
  task automatic predict_annexb(input logic [7:0] b, input logic last);
    int unsigned queued;
    queued = expected_annexb.size();
    if (unpack_mode != MODE_SINGLE && unpack_mode != MODE_FUA) begin
      // Dropping the rest of a bad payload; only its last byte matters.
      if (last) finish_payload();
    end else if (unpack_pos == POS_FIRST) begin
      live_bytes++;
      if (b[4:0] == FuAType) begin
        if (last) begin
          // An FU-A payload of one byte is too short.
          add_annexb(8'h00, 1'b1, 1'b0, 1'b1);
          finish_payload();
        end else begin
          fu_nri      = b[6:5];
          nal_begins  = 1'b0;
          unpack_mode = MODE_FUA;
          unpack_pos  = POS_SECOND;
        end
      end else if (b[4:0] != 5'd0 && b[4:0] < SingleLimit) begin
        // Single NAL unit: the header byte goes out as it is, behind the code.
        nal_begins = 1'b1;
        add_start_code(b, last);
        unpack_mode = MODE_SINGLE;
        unpack_pos  = POS_SECOND;
        if (last) finish_payload();
      end else begin
        // Type 0 and types 24 to 31 other than FU-A (aggregation and reserved types among them) are rejected.
        add_annexb(8'h00, 1'b1, 1'b0, 1'b1);
        if (last) finish_payload();
        else unpack_mode = MODE_DROP;
      end
    end else if (unpack_mode == MODE_FUA && unpack_pos == POS_SECOND) begin
      live_bytes++;
      if (last) begin
        // An FU-A payload that ends on its FU header has no data at all.
        add_annexb(8'h00, 1'b1, 1'b0, 1'b1);
        finish_payload();
      end else begin
        nal_begins = b[FuStartBit];
        if (nal_begins) add_start_code({1'b0, fu_nri, b[4:0]}, 1'b0);
        unpack_pos = POS_LATER;
      end
    end else begin
      live_bytes++;
      add_annexb(b, last, nal_begins, 1'b0);
      unpack_pos = POS_LATER;
      if (last) finish_payload();
    end
    if (expected_annexb.size() > queued) begin
      expected_annexb[expected_annexb.size() - 1].item_done = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Offers one payload byte, after a random gap, and holds it until the
  // transfer. The push stays high on return, so back-to-back bytes never see
  // push lowered and raised in the same time step.
  task automatic send_payload_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    payload_byte_i <= b;
    payload_end_i  <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_annexb(b, last);
  endtask

  // Sends a payload that starts with the given byte and continues with random
  // bytes up to the given length.
  task automatic send_payload(input logic [7:0] first, input int unsigned len);
    send_payload_byte(first, len == 1);
    for (int unsigned i = 1; i < len; i++) begin
      send_payload_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: checking, receiver stalls and the watchdog.
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    annexb_byte_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_annexb.size() == 0) begin
        $display("%0t: output byte with nothing expected, expected none, actual %h",
                 $time, out_byte_o);
        error_count++;
      end else begin
        want = expected_annexb.pop_front();
        check_field("out_byte", want.data, out_byte_o);
        check_field("item_done", 8'(want.item_done), 8'(item_done_o));
        check_field("payload_done", 8'(want.payload_done), 8'(payload_done_o));
        check_field("nal_start", 8'(want.nal_start), 8'(nal_start_o));
        check_field("status", 8'(want.status), 8'(status_o));
      end
    end
    pop <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d output bytes still expected",
               $time, stall_cycles, expected_annexb.size());
      $display("h264_rtp_depacketizer verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Single NAL units: a one-byte payload, and the extreme header and data
  // values behind the start code.
  task automatic test_single_nal();
    send_payload_byte(8'h01, 1'b1);
    send_payload_byte(8'hF7, 1'b0);
    send_payload_byte(8'h00, 1'b0);
    send_payload_byte(8'hFF, 1'b1);
  endtask

  // FU-A fragments: a start fragment with the largest NRI, an end fragment
  // without the start bit, and a start fragment whose FU header also has the
  // end bit and whose indicator has F set, so the rebuilt header must clear F.
  task automatic test_fu_a();
    send_payload_byte(8'h7C, 1'b0);
    send_payload_byte(8'h85, 1'b0);
    send_payload_byte(8'hAB, 1'b0);
    send_payload_byte(8'hCD, 1'b1);
    send_payload_byte(8'h1C, 1'b0);
    send_payload_byte(8'h45, 1'b0);
    send_payload_byte(8'h12, 1'b1);
    send_payload_byte(8'hFC, 1'b0);
    send_payload_byte(8'hDF, 1'b0);
    send_payload_byte(8'h00, 1'b1);
  endtask

  // Bad NAL types with and without trailing bytes to drop, and FU-A payloads
  // that end on the indicator byte or on the FU header.
  task automatic test_parse_errors();
    send_payload_byte(8'h00, 1'b0);
    send_payload_byte(8'h11, 1'b0);
    send_payload_byte(8'h22, 1'b1);
    send_payload_byte(8'h18, 1'b1);
    send_payload_byte(8'hFF, 1'b0);
    send_payload_byte(8'h01, 1'b1);
    send_payload_byte(8'h9C, 1'b1);
    send_payload_byte(8'h5C, 1'b0);
    send_payload_byte(8'h80, 1'b1);
  endtask

  // Random payloads, mostly well formed so that FU-A reassembly is reached
  // often; the rest are bad types, short FU-A payloads and plain noise.
  task automatic test_random_traffic(input int unsigned send_pct,
                                     input int unsigned recv_pct,
                                     input int unsigned byte_goal);
    int unsigned kind;
    int unsigned bad_pick;
    logic [4:0]  bad_type;
    int unsigned stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = live_bytes + byte_goal;
    while (live_bytes < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // A few long single NAL units, most of them short.
        send_payload({3'($urandom_range(7)), 5'($urandom_range(1, 23))},
                     ($urandom_range(9) == 0) ? $urandom_range(8, 20)
                                              : $urandom_range(1, 5));
      end else if (kind < 80) begin
        send_payload({3'($urandom_range(7)), FuAType}, $urandom_range(3, 7));
      end else if (kind < 88) begin
        // Pick one of type 0, 24 to 27 and 29 to 31.
        bad_pick = $urandom_range(7);
        bad_type = (bad_pick == 0) ? 5'd0
                 : (bad_pick < 5) ? 5'(23 + bad_pick) : 5'(24 + bad_pick);
        send_payload({3'($urandom_range(7)), bad_type}, $urandom_range(1, 4));
      end else if (kind < 94) begin
        send_payload({3'($urandom_range(7)), FuAType}, $urandom_range(1, 2));
      end else begin
        send_payload(8'($urandom_range(255)), $urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    unpack_mode = MODE_SINGLE;
    unpack_pos  = POS_FIRST;
    fu_nri      = 2'd0;
    nal_begins  = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 86;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_nal();
    test_fu_a();
    test_parse_errors();
    test_random_traffic(22, 86, 45);
    test_random_traffic(86, 22, 45);
    test_random_traffic(0, 0, 45);

    push <= 1'b0;
    while (expected_annexb.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("h264_rtp_depacketizer verification clean");
    end else begin
      $display("h264_rtp_depacketizer verification failed");
    end
    $finish;
  end

endmodule

// ===== h264_rtp_depacketizer.f =====
hw/rtl/h264rd_pkg.sv
hw/rtl/h264rd_front.sv
hw/rtl/h264rd_cmd_fifo.sv
hw/rtl/h264rd_back.sv
hw/rtl/h264_rtp_depacketizer.sv
bench/tb_h264_rtp_depacketizer.sv
